// ===== rtl/right_hand_wall_follower_unit_macros.svh =====
// assertion macros shared by the checker of the wall follower unit
// every macro samples on clk and is disabled while rst_n is low
`ifndef RIGHT_HAND_WALL_FOLLOWER_UNIT_MACROS_SVH
`define RIGHT_HAND_WALL_FOLLOWER_UNIT_MACROS_SVH

// condition must hold on every clock edge
`define RHWF_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent this cycle implies consequent in the same cycle
`define RHWF_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent this cycle implies consequent in the next cycle
`define RHWF_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rhwf_pkg.sv =====
// shared types, codes and sizes of the wall follower unit
// no dependencies; used by every rtl file but the macros header
`timescale 1ns / 1ps

package rhwf_pkg;

    // maze store geometry
    localparam int MAX_SIDE = 16;
    localparam int COORD_W  = 4;
    localparam int SIDE_W   = COORD_W + 1;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;

    // input opcodes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_STEP    = 2'd2;

    // output commands
    localparam logic [1:0] CMD_FWD    = 2'd0;
    localparam logic [1:0] CMD_RIGHT  = 2'd1;
    localparam logic [1:0] CMD_LEFT   = 2'd2;
    localparam logic [1:0] CMD_SOLVED = 2'd3;

    // headings
    localparam logic [1:0] DIR_E = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_W = 2'd2;
    localparam logic [1:0] DIR_N = 2'd3;

    // cell read slots of one step
    localparam logic [2:0] SEL_OWN   = 3'd0;
    localparam logic [2:0] SEL_EAST  = 3'd1;
    localparam logic [2:0] SEL_SOUTH = 3'd2;
    localparam logic [2:0] SEL_WEST  = 3'd3;
    localparam logic [2:0] SEL_NORTH = 3'd4;

    // side reset value and limits
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    typedef struct packed {
        logic [1:0]         opcode;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               n_wall;
        logic               e_wall;
        logic               s_wall;
        logic               w_wall;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [1:0]         facing;
        logic               last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       wr_en;
        logic       restart;
        logic       terminal;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       decide;
        logic       emit;
        logic [1:0] emit_idx;
        logic       emit_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       solved;
        logic       at_goal;
        logic [1:0] n_cmds;
    } dp_status_t;

endpackage

// ===== rtl/rhwf_ctrl.sv =====
// controller state machine of the wall follower unit
// depends on rhwf_pkg; drives rhwf_datapath through dp_cmd_t
`timescale 1ns / 1ps

module rhwf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            opcode,
    input  rhwf_pkg::dp_status_t  status,
    output rhwf_pkg::dp_cmd_t     cmd,
    output logic                  busy,
    output logic                  result_strobe
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SETTLE,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] rd_cnt_reg, rd_cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       strobe_reg, strobe_next;

    // next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        rhwf_pkg::OP_WRITE:
                        begin
                            cmd.wr_en = 1'b1;
                        end
                        rhwf_pkg::OP_RESTART:
                        begin
                            cmd.restart = 1'b1;
                            idx_next    = 2'd0;
                            state_next  = S_EMIT;
                        end
                        rhwf_pkg::OP_STEP:
                        begin
                            if (status.solved || status.at_goal)
                            begin
                                cmd.terminal = 1'b1;
                                idx_next     = 2'd0;
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                rd_cnt_next = rhwf_pkg::SEL_OWN;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rd_cnt_reg;
                if (rd_cnt_reg == rhwf_pkg::SEL_NORTH)
                begin
                    state_next = S_SETTLE;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end
            end
            S_SETTLE:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                idx_next   = 2'd0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_idx  = idx_reg;
                cmd.emit_last = ((idx_reg + 2'd1) == status.n_cmds);
                if (cmd.emit_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        strobe_next = cmd.emit;
    end

    // state and registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_cnt_reg <= rhwf_pkg::SEL_OWN;
            idx_reg    <= 2'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;

endmodule

// ===== rtl/rhwf_datapath.sv =====
// datapath of the wall follower unit: cell store, walker state, command list
// depends on rhwf_pkg; commanded by rhwf_ctrl
`timescale 1ns / 1ps

module rhwf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rhwf_pkg::in_item_t            item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rhwf_pkg::SIDE_W-1:0]   cfg_data,
    input  rhwf_pkg::dp_cmd_t             cmd,
    output rhwf_pkg::dp_status_t          status,
    output rhwf_pkg::out_item_t           result
);

    localparam int CW = rhwf_pkg::COORD_W;
    localparam int SW = rhwf_pkg::SIDE_W;

    // cell store: bit0 north, bit1 east, bit2 south, bit3 west
    logic [3:0] mem [rhwf_pkg::CELLS];
    logic [3:0] rd_data_reg;
    logic [rhwf_pkg::ADDR_W-1:0] rd_addr;

    logic [SW-1:0] maze_side_reg;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] y_reg, y_next;
    logic [1:0]    h_reg, h_next;
    logic          solved_reg;
    logic          cap_en_reg;
    logic [2:0]    cap_sel_reg;
    logic [3:0]    blk_reg;
    logic [2:0][1:0] cmds_reg, cmds_next;
    logic [1:0]    n_cmds_reg, n_cmds_next;
    logic          load_cmds;
    rhwf_pkg::out_item_t res_reg;

    logic [SW-1:0] side, lim;
    logic          inr_e, inr_s, inr_w, inr_n;
    logic [1:0]    right_dir, left_dir;
    logic [SW-1:0] x_mv, y_mv;

    assign cfg_ready = 1'b1;

    // clamped side and goal test
    always_comb
    begin
        side = maze_side_reg;
        if (maze_side_reg < rhwf_pkg::SIDE_MIN)
        begin
            side = rhwf_pkg::SIDE_MIN;
        end
        else if (maze_side_reg > rhwf_pkg::SIDE_MAX)
        begin
            side = rhwf_pkg::SIDE_MAX;
        end
        lim = side - SW'(1);
    end

    assign status.solved  = solved_reg;
    assign status.at_goal = ({1'b0, x_reg} == lim) && ({1'b0, y_reg} == lim);
    assign status.n_cmds  = n_cmds_reg;

    // neighbours inside the grid
    assign inr_e = (({1'b0, x_reg} + SW'(1)) < side);
    assign inr_s = (({1'b0, y_reg} + SW'(1)) < side);
    assign inr_w = (x_reg != '0);
    assign inr_n = (y_reg != '0);

    // read address of the current slot
    always_comb
    begin
        case (cmd.rd_sel)
            rhwf_pkg::SEL_EAST:  rd_addr = {y_reg, x_reg + CW'(1)};
            rhwf_pkg::SEL_SOUTH: rd_addr = {y_reg + CW'(1), x_reg};
            rhwf_pkg::SEL_WEST:  rd_addr = {y_reg, x_reg - CW'(1)};
            rhwf_pkg::SEL_NORTH: rd_addr = {y_reg - CW'(1), x_reg};
            default:             rd_addr = {y_reg, x_reg};
        endcase
    end

    // cell store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[{item.cell_y, item.cell_x}] <= {item.w_wall, item.s_wall,
                                                item.e_wall, item.n_wall};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // merge read data into blocked flags, indexed by heading
    always_ff @(posedge clk)
    begin
        if (cap_en_reg)
        begin
            case (cap_sel_reg)
                rhwf_pkg::SEL_OWN:
                    blk_reg <= {rd_data_reg[0], rd_data_reg[3:1]};
                rhwf_pkg::SEL_EAST:
                    blk_reg[rhwf_pkg::DIR_E] <= blk_reg[rhwf_pkg::DIR_E] |
                                                (inr_e & rd_data_reg[3]);
                rhwf_pkg::SEL_SOUTH:
                    blk_reg[rhwf_pkg::DIR_S] <= blk_reg[rhwf_pkg::DIR_S] |
                                                (inr_s & rd_data_reg[0]);
                rhwf_pkg::SEL_WEST:
                    blk_reg[rhwf_pkg::DIR_W] <= blk_reg[rhwf_pkg::DIR_W] |
                                                (inr_w & rd_data_reg[1]);
                rhwf_pkg::SEL_NORTH:
                    blk_reg[rhwf_pkg::DIR_N] <= blk_reg[rhwf_pkg::DIR_N] |
                                                (inr_n & rd_data_reg[2]);
                default:
                begin
                end
            endcase
        end
    end

    // turn choice, command list and move
    always_comb
    begin
        right_dir   = h_reg + 2'd1;
        left_dir    = h_reg + 2'd3;
        h_next      = h_reg;
        cmds_next   = cmds_reg;
        n_cmds_next = n_cmds_reg;
        load_cmds   = 1'b0;
        x_mv        = {1'b0, x_reg};
        y_mv        = {1'b0, y_reg};
        x_next      = x_reg;
        y_next      = y_reg;
        if (cmd.restart)
        begin
            load_cmds    = 1'b1;
            cmds_next[0] = rhwf_pkg::CMD_FWD;
            n_cmds_next  = 2'd1;
            h_next       = rhwf_pkg::DIR_E;
            x_next       = '0;
            y_next       = '0;
        end
        else if (cmd.terminal)
        begin
            load_cmds = 1'b1;
            if (solved_reg)
            begin
                cmds_next[0] = rhwf_pkg::CMD_SOLVED;
                n_cmds_next  = 2'd1;
            end
            else if (h_reg == rhwf_pkg::DIR_E)
            begin
                cmds_next[0] = rhwf_pkg::CMD_FWD;
                cmds_next[1] = rhwf_pkg::CMD_SOLVED;
                n_cmds_next  = 2'd2;
            end
            else
            begin
                cmds_next[0] = rhwf_pkg::CMD_LEFT;
                cmds_next[1] = rhwf_pkg::CMD_FWD;
                cmds_next[2] = rhwf_pkg::CMD_SOLVED;
                n_cmds_next  = 2'd3;
            end
        end
        else if (cmd.decide)
        begin
            load_cmds = 1'b1;
            if (!blk_reg[right_dir])
            begin
                cmds_next[0] = rhwf_pkg::CMD_RIGHT;
                cmds_next[1] = rhwf_pkg::CMD_FWD;
                n_cmds_next  = 2'd2;
                h_next       = right_dir;
            end
            else if (!blk_reg[h_reg])
            begin
                cmds_next[0] = rhwf_pkg::CMD_FWD;
                n_cmds_next  = 2'd1;
            end
            else if (!blk_reg[left_dir])
            begin
                cmds_next[0] = rhwf_pkg::CMD_LEFT;
                cmds_next[1] = rhwf_pkg::CMD_FWD;
                n_cmds_next  = 2'd2;
                h_next       = left_dir;
            end
            else
            begin
                // dead end: turn around and move back, even into a wall
                cmds_next[0] = rhwf_pkg::CMD_RIGHT;
                cmds_next[1] = rhwf_pkg::CMD_RIGHT;
                cmds_next[2] = rhwf_pkg::CMD_FWD;
                n_cmds_next  = 2'd3;
                h_next       = h_reg + 2'd2;
            end
            case (h_next)
                rhwf_pkg::DIR_E: x_mv = {1'b0, x_reg} + SW'(1);
                rhwf_pkg::DIR_S: y_mv = {1'b0, y_reg} + SW'(1);
                rhwf_pkg::DIR_W: x_mv = inr_w ? ({1'b0, x_reg} - SW'(1)) : {1'b0, x_reg};
                default:         y_mv = inr_n ? ({1'b0, y_reg} - SW'(1)) : {1'b0, y_reg};
            endcase
            // clamp both coordinates to the grid
            if (x_mv > lim)
            begin
                x_mv = lim;
            end
            if (y_mv > lim)
            begin
                y_mv = lim;
            end
            x_next = x_mv[CW-1:0];
            y_next = y_mv[CW-1:0];
        end
    end

    // walker state, side register and capture control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_side_reg <= rhwf_pkg::SIDE_RESET;
            x_reg         <= '0;
            y_reg         <= '0;
            h_reg         <= rhwf_pkg::DIR_E;
            solved_reg    <= 1'b0;
            n_cmds_reg    <= 2'd1;
            cap_en_reg    <= 1'b0;
            cap_sel_reg   <= rhwf_pkg::SEL_OWN;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                maze_side_reg <= cfg_data;
            end
            x_reg      <= x_next;
            y_reg      <= y_next;
            h_reg      <= h_next;
            n_cmds_reg <= n_cmds_next;
            if (cmd.restart)
            begin
                solved_reg <= 1'b0;
            end
            else if (cmd.terminal)
            begin
                solved_reg <= 1'b1;
            end
            cap_en_reg  <= cmd.rd_en;
            cap_sel_reg <= cmd.rd_sel;
        end
    end

    // command list and result register
    always_ff @(posedge clk)
    begin
        if (load_cmds)
        begin
            cmds_reg <= cmds_next;
        end
        if (cmd.emit)
        begin
            res_reg.command <= cmds_reg[cmd.emit_idx];
            res_reg.pos_x   <= x_reg;
            res_reg.pos_y   <= y_reg;
            res_reg.facing  <= h_reg;
            res_reg.last    <= cmd.emit_last;
        end
    end

    assign result = res_reg;

endmodule

// ===== rtl/right_hand_wall_follower_unit.sv =====
// Right-hand wall follower for a square grid maze of up to 16 by 16 cells.
// Input channel: an item is taken when start is high and busy is low. Opcode
// write stores the four wall bits of one cell, restart puts the walker at
// (0,0) facing east, step moves the walker one cell by the right-hand rule.
// Write items leave busy low; the host writes every cell
// before the first step.
// Result channel: result_strobe marks each result for one cycle; one to three
// results per restart or step, in consecutive cycles, last set on the final
// one. The receiver cannot stall, so nothing is ever held back.
// Config channel: cfg_data sets the side length (reset 8); cfg_ready is
// always high; write only while busy is low.
// Sequence: a normal step reads its own cell and four neighbours from the
// cell store, one per cycle, then passes a settle state and decides; busy
// stays high until its emit state ends, and the results follow. A restart,
// a step at the goal or a step after solving skips the reads and goes
// straight to its emit state.
// Reset clears the walker to (0,0) east, unsolved; the cell store keeps its
// contents and needs no clearing.
`timescale 1ns / 1ps

module right_hand_wall_follower_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rhwf_pkg::in_item_t            item,
    output logic                          result_strobe,
    output rhwf_pkg::out_item_t           result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rhwf_pkg::SIDE_W-1:0]   cfg_data
);

    rhwf_pkg::dp_cmd_t    cmd;
    rhwf_pkg::dp_status_t status;

    // sequencing of each item
    rhwf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (item.opcode),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    // cell store and walker
    rhwf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

// ===== rtl/rhwf_checker.sv =====
// port-level checks of the wall follower unit, bound to the top level
// depends on rhwf_pkg and right_hand_wall_follower_unit_macros.svh
`timescale 1ns / 1ps
`include "right_hand_wall_follower_unit_macros.svh"

module rhwf_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input rhwf_pkg::in_item_t   item,
    input logic                 result_strobe,
    input rhwf_pkg::out_item_t  result
);

    logic take_run;
    logic take_write;

    assign take_run   = start && !busy && ((item.opcode == rhwf_pkg::OP_RESTART) ||
                                           (item.opcode == rhwf_pkg::OP_STEP));
    assign take_write = start && !busy && (item.opcode == rhwf_pkg::OP_WRITE);

    // a restart or step item holds off the next item
    `RHWF_NEXT(a_run_busy, take_run, busy, "no busy after restart or step item")

    // a write item causes no result
    `RHWF_NEXT(a_write_quiet, take_write, !result_strobe, "result after write item")

    // results of one item come in consecutive cycles
    `RHWF_NEXT(a_burst, result_strobe && !result.last, result_strobe,
               "gap inside result burst")

    // a gap follows the final result of an item
    `RHWF_NEXT(a_gap, result_strobe && result.last, !result_strobe,
               "result right after final result")

    // solved always ends the item
    `RHWF_IMPLY(a_solved_last, result_strobe && (result.command == rhwf_pkg::CMD_SOLVED),
                result.last, "solved command not final")

endmodule

bind right_hand_wall_follower_unit rhwf_checker u_rhwf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench of the right-hand wall follower unit: directed walks, then random mazes
// depends on rhwf_pkg and right_hand_wall_follower_unit; results checked by an in-bench walker

module testbench;
    import rhwf_pkg::*;

    // opcode that the block ignores
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // bit positions in a cell's wall nibble
    localparam int WALL_N = 0;
    localparam int WALL_E = 1;
    localparam int WALL_S = 2;
    localparam int WALL_W = 3;

    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 160;

    typedef enum logic {HOST_ITEM, HOST_SIDE} host_kind_t;

    typedef struct packed {
        host_kind_t         kind;
        in_item_t           item;
        logic [SIDE_W-1:0]  side;
        logic [6:0]         idle_pct;
    } host_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    in_item_t           item = '0;
    logic               result_strobe;
    out_item_t          result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SIDE_W-1:0]  cfg_data = '0;

    // stimulus side
    host_entry_t        host_items[$];
    logic [3:0]         plan [MAX_SIDE][MAX_SIDE];
    int                 idle_now = 0;
    int                 fed_items = 0;
    logic               took_item = 1'b0;
    logic               took_cfg = 1'b0;
    int                 quiet_cycles = 0;

    // walker model
    logic [3:0]         walls_seen [MAX_SIDE][MAX_SIDE];
    logic [COORD_W-1:0] walker_col = '0;
    logic [COORD_W-1:0] walker_row = '0;
    logic [1:0]         walker_dir = DIR_E;
    logic               walker_done = 1'b0;
    logic [SIDE_W-1:0]  side_reg = SIDE_RESET;
    out_item_t          expected_cmds[$];
    int                 mismatches = 0;

    right_hand_wall_follower_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // walls of an open floor fenced at side s
    function automatic logic [3:0] border_walls(int x, int y, int s);
        logic [3:0] w;
        w = '0;
        w[WALL_N] = (y == 0);
        w[WALL_S] = (y == s - 1);
        w[WALL_W] = (x == 0);
        w[WALL_E] = (x == s - 1);
        return w;
    endfunction

    function automatic int wall_index(logic [1:0] d);
        case (d)
            DIR_E:   return WALL_E;
            DIR_S:   return WALL_S;
            DIR_W:   return WALL_W;
            default: return WALL_N;
        endcase
    endfunction

    // a side is shut if the walker's cell or the neighbour across it says so
    function automatic bit side_closed(logic [1:0] d, int s);
        int cx;
        int cy;
        logic [3:0] own;
        cx = walker_col;
        cy = walker_row;
        own = walls_seen[cy][cx];
        if (own[wall_index(d)])
            return 1'b1;
        case (d)
            DIR_E:   if (cx + 1 < s) return walls_seen[cy][cx + 1][WALL_W];
            DIR_S:   if (cy + 1 < s) return walls_seen[cy + 1][cx][WALL_N];
            DIR_W:   if (cx > 0) return walls_seen[cy][cx - 1][WALL_E];
            default: if (cy > 0) return walls_seen[cy - 1][cx][WALL_S];
        endcase
        return 1'b0;
    endfunction

    // fold one accepted item into the walker and queue the commands it causes
    task automatic follow_wall(in_item_t it);
        logic [1:0] cmds[$];
        logic [1:0] rdir;
        logic [1:0] ldir;
        out_item_t r;
        int s;
        int nx;
        int ny;
        case (it.opcode)
            OP_WRITE:
            begin
                walls_seen[it.cell_y][it.cell_x] =
                    {it.w_wall, it.s_wall, it.e_wall, it.n_wall};
            end
            OP_RESTART:
            begin
                walker_col = '0;
                walker_row = '0;
                walker_dir = DIR_E;
                walker_done = 1'b0;
                cmds.push_back(CMD_FWD);
            end
            OP_STEP:
            begin
                s = (side_reg < SIDE_MIN) ? SIDE_MIN :
                    (side_reg > SIDE_MAX) ? SIDE_MAX : side_reg;
                if (walker_done)
                begin
                    cmds.push_back(CMD_SOLVED);
                end
                else if (walker_col == s - 1 && walker_row == s - 1)
                begin
                    // exit sequence at the far corner
                    if (walker_dir != DIR_E)
                        cmds.push_back(CMD_LEFT);
                    cmds.push_back(CMD_FWD);
                    cmds.push_back(CMD_SOLVED);
                    walker_done = 1'b1;
                end
                else
                begin
                    rdir = walker_dir + 2'd1;
                    ldir = walker_dir + 2'd3;
                    if (!side_closed(rdir, s))
                    begin
                        cmds.push_back(CMD_RIGHT);
                        walker_dir = rdir;
                    end
                    else if (side_closed(walker_dir, s))
                    begin
                        if (!side_closed(ldir, s))
                        begin
                            cmds.push_back(CMD_LEFT);
                            walker_dir = ldir;
                        end
                        else
                        begin
                            // dead end: turn around even if walled behind
                            cmds.push_back(CMD_RIGHT);
                            cmds.push_back(CMD_RIGHT);
                            walker_dir = walker_dir + 2'd2;
                        end
                    end
                    cmds.push_back(CMD_FWD);
                    // one cell ahead, clamped to the grid
                    nx = walker_col;
                    ny = walker_row;
                    case (walker_dir)
                        DIR_E:   nx = nx + 1;
                        DIR_S:   ny = ny + 1;
                        DIR_W:   if (nx > 0) nx = nx - 1;
                        default: if (ny > 0) ny = ny - 1;
                    endcase
                    if (nx > s - 1) nx = s - 1;
                    if (ny > s - 1) ny = s - 1;
                    walker_col = COORD_W'(nx);
                    walker_row = COORD_W'(ny);
                end
            end
            default: ;
        endcase
        for (int k = 0; k < cmds.size(); k++)
        begin
            r.command = cmds[k];
            r.pos_x = walker_col;
            r.pos_y = walker_row;
            r.facing = walker_dir;
            r.last = (k == cmds.size() - 1);
            expected_cmds.push_back(r);
        end
    endtask

    task automatic flag_result(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $write("%0t %s: expected cmd %0d pos (%0d,%0d) facing %0d last %0d,",
                   $realtime, what, want.command, want.pos_x, want.pos_y, want.facing,
                   want.last);
            $display(" got cmd %0d pos (%0d,%0d) facing %0d last %0d",
                     got.command, got.pos_x, got.pos_y, got.facing, got.last);
        end
    endtask

    task automatic push_item(logic [1:0] op, int x, int y, logic [3:0] walls);
        host_entry_t e;
        e.kind = HOST_ITEM;
        e.item.opcode = op;
        e.item.cell_x = COORD_W'(x);
        e.item.cell_y = COORD_W'(y);
        e.item.n_wall = walls[WALL_N];
        e.item.e_wall = walls[WALL_E];
        e.item.s_wall = walls[WALL_S];
        e.item.w_wall = walls[WALL_W];
        e.side = '0;
        e.idle_pct = 7'(idle_now);
        host_items.push_back(e);
        if (op != OP_IGNORED)
            fed_items++;
    endtask

    // non-write items carry random payload the block must not look at
    task automatic push_cmd(logic [1:0] op);
        push_item(op, 4'($urandom), 4'($urandom), 4'($urandom));
    endtask

    task automatic push_side(int v);
        host_entry_t e;
        e = '0;
        e.kind = HOST_SIDE;
        e.side = SIDE_W'(v);
        host_items.push_back(e);
    endtask

    // binary tree maze: every cell but (0,0) opens west or north, so the maze is perfect
    task automatic build_maze(int s);
        for (int y = 0; y < s; y++)
            for (int x = 0; x < s; x++)
                plan[y][x] = 4'hF;
        for (int y = 0; y < s; y++)
            for (int x = 0; x < s; x++)
            begin
                if (x == 0 && y == 0)
                    continue;
                if (y == 0 || (x > 0 && $urandom_range(0, 1) == 0))
                begin
                    plan[y][x][WALL_W] = 1'b0;
                    plan[y][x - 1][WALL_E] = 1'b0;
                end
                else
                begin
                    plan[y][x][WALL_N] = 1'b0;
                    plan[y - 1][x][WALL_S] = 1'b0;
                end
            end
    endtask

    // driver: one item or side write at a time, changed at the falling edge
    always @(negedge clk)
    begin : drive
        logic next_start;
        logic next_cfg;
        host_entry_t head;
        next_start = start && !took_item;
        next_cfg = cfg_valid && !took_cfg;
        if (rst_n && !next_start && !next_cfg && host_items.size() != 0)
        begin
            head = host_items[0];
            if (head.kind == HOST_SIDE)
            begin
                // side changes only once the block has gone quiet
                if (quiet_cycles >= SETTLE_CYCLES)
                begin
                    next_cfg = 1'b1;
                    cfg_data <= head.side;
                    void'(host_items.pop_front());
                end
            end
            else if ($urandom_range(1, 100) > head.idle_pct)
            begin
                next_start = 1'b1;
                item <= head.item;
                void'(host_items.pop_front());
            end
        end
        start <= next_start;
        cfg_valid <= next_cfg;
    end

    // monitor: check each result, then fold accepted items into the model
    always @(posedge clk)
    begin : observe
        out_item_t want;
        if (rst_n)
        begin
            if (result_strobe)
            begin
                if (expected_cmds.size() == 0)
                begin
                    flag_result("result with nothing expected", '0, result);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (result.command !== want.command || result.pos_x !== want.pos_x ||
                        result.pos_y !== want.pos_y || result.facing !== want.facing ||
                        result.last !== want.last)
                        flag_result("result mismatch", want, result);
                end
            end
            if (cfg_valid && cfg_ready)
                side_reg = cfg_data;
            if (start && !busy)
                follow_wall(item);
            if (start || busy || result_strobe || expected_cmds.size() != 0)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        took_item <= rst_n && start && !busy;
        took_cfg <= rst_n && cfg_valid && cfg_ready;
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        int s;
        int v;
        int r;
        int steps;
        int k;
        int random_base;
        int round_no;

        for (int y = 0; y < MAX_SIDE; y++)
            for (int x = 0; x < MAX_SIDE; x++)
                walls_seen[y][x] = '0;

        // whole store: open floor fenced only at the store border
        for (int y = 0; y < MAX_SIDE; y++)
            for (int x = 0; x < MAX_SIDE; x++)
                push_item(OP_WRITE, x, y, border_walls(x, y, MAX_SIDE));

        // side still at reset: walk down the west edge, then stall at the open grid edge
        push_cmd(OP_RESTART);
        repeat (8) push_cmd(OP_STEP);
        push_cmd(OP_IGNORED);

        // raw side 0 acts as 2: fenced 2x2 floor, exit facing east, then solved only
        push_side(0);
        for (int y = 0; y < 2; y++)
            for (int x = 0; x < 2; x++)
                push_item(OP_WRITE, x, y, border_walls(x, y, 2));
        push_cmd(OP_RESTART);
        repeat (4) push_cmd(OP_STEP);

        // south wall at the start: goal reached facing south
        push_item(OP_WRITE, 0, 0, border_walls(0, 0, 2) | (4'b1 << WALL_S));
        push_cmd(OP_RESTART);
        repeat (3) push_cmd(OP_STEP);

        // walled in on all sides: turn around clamped, then turn around again
        push_item(OP_WRITE, 0, 0, 4'hF);
        push_cmd(OP_RESTART);
        repeat (2) push_cmd(OP_STEP);

        random_base = fed_items;

        // corridor run over the whole store with raw side 31
        idle_now = 53;
        push_side(31);
        for (int y = 0; y < 2; y++)
            for (int x = 0; x < 2; x++)
                push_item(OP_WRITE, x, y, border_walls(x, y, MAX_SIDE));
        push_cmd(OP_RESTART);
        repeat (32) push_cmd(OP_STEP);

        round_no = 0;
        while (fed_items - random_base < RANDOM_ITEMS)
        begin
            case (round_no % 3)
                0:       idle_now = 0;
                1:       idle_now = 53;
                default: idle_now = 10;
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                // short noisy run at any raw side
                if ($urandom_range(0, 1) == 0)
                begin
                    v = $urandom_range(0, 31);
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 0;
                        1:       v = 1;
                        2:       v = 16;
                        default: v = 31;
                    endcase
                end
                push_side(v);
                push_cmd(OP_RESTART);
                steps = $urandom_range(6, 12);
                repeat (steps)
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_item(OP_WRITE, 4'($urandom), 4'($urandom), 4'($urandom));
                    push_cmd(OP_STEP);
                end
            end
            else
            begin
                // perfect maze, solved by the walker unless noise gets in the way
                s = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 8) : $urandom_range(2, 5);
                build_maze(s);
                if ($urandom_range(0, 3) == 0)
                begin
                    k = $urandom_range(0, s - 1);
                    case ($urandom_range(0, 3))
                        0:       plan[0][k][WALL_N] = 1'b0;
                        1:       plan[k][s - 1][WALL_E] = 1'b0;
                        2:       plan[s - 1][k][WALL_S] = 1'b0;
                        default: plan[k][0][WALL_W] = 1'b0;
                    endcase
                end
                v = s;
                if (s == 2 && $urandom_range(0, 2) == 0)
                    v = $urandom_range(0, 1);
                push_side(v);
                for (int y = 0; y < s; y++)
                    for (int x = 0; x < s; x++)
                        push_item(OP_WRITE, x, y, plan[y][x]);
                push_cmd(OP_RESTART);
                steps = 2 * (s * s - 1) + $urandom_range(1, 3);
                repeat (steps)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        push_item(OP_WRITE, 4'($urandom), 4'($urandom), 4'($urandom));
                    else if (r < 7)
                        push_cmd(OP_IGNORED);
                    else if (r < 9)
                        push_cmd(OP_RESTART);
                    push_cmd(OP_STEP);
                end
            end
            round_no++;
        end

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain
        while (host_items.size() != 0 || start || cfg_valid || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_cmds.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", expected_cmds.size());
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rhwf_pkg.sv
rtl/rhwf_ctrl.sv
rtl/rhwf_datapath.sv
rtl/right_hand_wall_follower_unit.sv
rtl/rhwf_checker.sv
dv/testbench.sv
